[rtl/enc_sdm_pkg.sv]
// ----------------------------------------------------------------------------
// Encoder speed/direction meter package
// Shared constants, command codes and register indexes for the meter.
// ----------------------------------------------------------------------------
`default_nettype none

package enc_sdm_pkg;

   // Default width of the free-running capture timer.
   localparam int STAMP_WIDTH_DEFAULT = 32;

   // Item command codes.
   localparam int CMD_WIDTH = 2;
   localparam logic [CMD_WIDTH-1:0] CMD_EDGE   = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_REPORT = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   // Result field widths.
   localparam int SCALED_WIDTH = 27;
   localparam int SPEED_WIDTH  = 32;
   localparam int DIR_WIDTH    = 2;

   // Direction codes.
   localparam logic signed [DIR_WIDTH-1:0] DIR_STOP = 2'sd0;
   localparam logic signed [DIR_WIDTH-1:0] DIR_CW   = 2'sd1;
   localparam logic signed [DIR_WIDTH-1:0] DIR_CCW  = -2'sd1;

   // Arithmetic constants.
   localparam int PERIOD_DIVISOR = 60;
   localparam int TICK_WIDTH     = 8;
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = 8'd255;

   // Configuration registers.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_NUMERATOR = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STALL_LIMIT     = 1'd1;
   localparam logic [TICK_WIDTH-1:0] STALL_LIMIT_RESET = 8'd2;

endpackage

`default_nettype wire

[rtl/enc_sdm_if.sv]
// ----------------------------------------------------------------------------
// Encoder speed/direction meter channels
// Valid/ready channels for request items and report items.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: capture edge, timeout tick or report request.
interface enc_sdm_req_if #(
   parameter int STAMP_WIDTH = enc_sdm_pkg::STAMP_WIDTH_DEFAULT
);
   logic                                 valid;
   logic                                 ready;
   logic [enc_sdm_pkg::CMD_WIDTH-1:0]    cmd;
   logic [STAMP_WIDTH-1:0]               timestamp;
   logic                                 channel_b;

   modport source (output valid, cmd, timestamp, channel_b, input ready);
   modport sink   (input valid, cmd, timestamp, channel_b, output ready);
endinterface

// Report channel: scaled period, speed and direction.
interface enc_sdm_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic [enc_sdm_pkg::SCALED_WIDTH-1:0]        period_scaled;
   logic [enc_sdm_pkg::SPEED_WIDTH-1:0]         speed;
   logic signed [enc_sdm_pkg::DIR_WIDTH-1:0]    direction;

   modport source (output valid, period_scaled, speed, direction, input ready);
   modport sink   (input valid, period_scaled, speed, direction, output ready);
endinterface

`default_nettype wire

[rtl/encoder_speed_direction_meter.sv]
// ----------------------------------------------------------------------------
// Encoder speed and direction meter
// Period measurement of a quadrature encoder with one shared bit-serial divider.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake     Payload
//  req_if    in   valid/ready   cmd, timestamp, channel_b
//  rsp_if    out  valid/ready   period_scaled, speed, direction
//  csr_*     in   write enable  csr_index, csr_wdata
//
//  Edge, tick and unused items complete when accepted. A report runs through
//  accept, shift-add steps and a closing step for period/60, DW divider steps
//  for numerator/period, then one output load. A zero period skips the
//  divider and a stalled report skips both.
//  Reset is synchronous and active high; req_if.ready is low while a report
//  is in progress or while its item waits for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_direction_meter #(
   parameter int STAMP_WIDTH = enc_sdm_pkg::STAMP_WIDTH_DEFAULT
) (
   input  wire                                        clock,
   input  wire                                        reset,
   enc_sdm_req_if.sink                                req_if,
   enc_sdm_rsp_if.source                              rsp_if,
   input  wire                                        csr_we,
   input  wire [enc_sdm_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire [enc_sdm_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   localparam int SW    = STAMP_WIDTH;
   localparam int DW    = (STAMP_WIDTH > 32) ? STAMP_WIDTH : 32;
   localparam int CNT_W = $clog2(DW);
   localparam int SCW   = enc_sdm_pkg::SCALED_WIDTH;
   localparam int SPW   = enc_sdm_pkg::SPEED_WIDTH;
   localparam int TW    = enc_sdm_pkg::TICK_WIDTH;
   localparam int DRW   = enc_sdm_pkg::DIR_WIDTH;

   localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(DW - 1);
   localparam logic [DW-1:0]    SCALED_MAX = DW'({SCW{1'b1}});

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV_P = 2'd1;
   localparam logic [1:0] ST_DIV_S = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   // Configuration registers.
   logic [SPW-1:0] numerator_ff;
   logic [TW-1:0]  stall_limit_ff;

   // Measurement state.
   logic [SW-1:0]            last_stamp_ff, last_stamp_in;
   logic [SW-1:0]            period_ff, period_in;
   logic signed [DRW-1:0]    dir_ff, dir_in;
   logic [TW-1:0]            tick_ff, tick_in;
   logic                     first_edge_ff, first_edge_in;
   logic [SPW-1:0]           held_speed_ff, held_speed_in;

   // Sequencer and shared divider.
   logic [1:0]               state_ff, state_in;
   logic [DW-1:0]            quo_ff, quo_in;
   logic [DW-1:0]            rem_ff, rem_in;
   logic [DW-1:0]            dvs_ff, dvs_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   // Pending report and output register.
   logic [SCW-1:0]           res_scaled_ff, res_scaled_in;
   logic [SPW-1:0]           res_speed_ff, res_speed_in;
   logic signed [DRW-1:0]    res_dir_ff, res_dir_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SCW-1:0]           rsp_scaled_ff, rsp_scaled_in;
   logic [SPW-1:0]           rsp_speed_ff, rsp_speed_in;
   logic signed [DRW-1:0]    rsp_dir_ff, rsp_dir_in;

   // Divider step signals.
   logic [DW:0]              trial;
   logic [DW:0]              diff;
   logic [DW-1:0]            step_quo;
   logic [DW-1:0]            step_rem;
   logic                     accept;
   logic                     out_free;

   // Division by 15 step signals.
   logic [DW-1:0]            nib_hi;
   logic [DW-1:0]            div15_quo;

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign accept               = req_if.valid && (state_ff == ST_IDLE);
   assign out_free             = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.period_scaled = rsp_scaled_ff;
   assign rsp_if.speed         = rsp_speed_ff;
   assign rsp_if.direction     = rsp_dir_ff;

   // Upper part of the running value and the closing quotient for n/15.
   assign nib_hi    = rem_ff >> 4;
   assign div15_quo = quo_ff + DW'(rem_ff[3:0] == 4'hF);

   // One restoring division step: shift in the next dividend bit, subtract
   // the divisor when it fits.
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diff  = trial - {1'b0, dvs_ff};
      if (!diff[DW]) begin
         step_rem = diff[DW-1:0];
         step_quo = {quo_ff[DW-2:0], 1'b1};
      end else begin
         step_rem = trial[DW-1:0];
         step_quo = {quo_ff[DW-2:0], 1'b0};
      end
   end

   // Next-state logic for the sequencer, the state and the output register.
   always_comb begin
      last_stamp_in = last_stamp_ff;
      period_in     = period_ff;
      dir_in        = dir_ff;
      tick_in       = tick_ff;
      first_edge_in = first_edge_ff;
      held_speed_in = held_speed_ff;
      state_in      = state_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      cnt_in        = cnt_ff;
      res_scaled_in = res_scaled_ff;
      res_speed_in  = res_speed_ff;
      res_dir_in    = res_dir_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_dir_in    = rsp_dir_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_if.cmd)
                  enc_sdm_pkg::CMD_EDGE: begin
                     if (first_edge_ff) begin
                        first_edge_in = 1'b0;
                     end else begin
                        period_in = req_if.timestamp - last_stamp_ff;
                     end
                     last_stamp_in = req_if.timestamp;
                     dir_in  = req_if.channel_b ? enc_sdm_pkg::DIR_CW
                                                : enc_sdm_pkg::DIR_CCW;
                     tick_in = '0;
                  end
                  enc_sdm_pkg::CMD_TICK: begin
                     if (tick_ff != enc_sdm_pkg::TICK_MAX) begin
                        tick_in = tick_ff + TW'(1);
                     end
                  end
                  enc_sdm_pkg::CMD_REPORT: begin
                     if (tick_ff >= stall_limit_ff) begin
                        // Stopped: report zeros and re-arm first-edge handling.
                        held_speed_in = '0;
                        first_edge_in = 1'b1;
                        res_scaled_in = '0;
                        res_speed_in  = '0;
                        res_dir_in    = enc_sdm_pkg::DIR_STOP;
                        state_in      = ST_WAIT;
                     end else begin
                        // The period over 60 is the period over 4, then over 15.
                        res_dir_in = dir_ff;
                        quo_in     = '0;
                        rem_in     = DW'(period_ff) >> 2;
                        state_in   = ST_DIV_P;
                     end
                  end
                  enc_sdm_pkg::CMD_UNUSED: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV_P: begin
            if (nib_hi != '0) begin
               // With n = 16a + b, n/15 = a + (a + b)/15: bank a, go on with a + b.
               quo_in = quo_ff + nib_hi;
               rem_in = nib_hi + DW'(rem_ff[3:0]);
            end else begin
               // Below 16 only the value 15 itself adds one more.
               res_scaled_in = (div15_quo > SCALED_MAX) ? {SCW{1'b1}} : div15_quo[SCW-1:0];
               if (period_ff != '0) begin
                  quo_in   = DW'(numerator_ff);
                  rem_in   = '0;
                  dvs_in   = DW'(period_ff);
                  cnt_in   = CNT_LAST;
                  state_in = ST_DIV_S;
               end else begin
                  // Zero period keeps the last reported speed.
                  res_speed_in = held_speed_ff;
                  state_in     = ST_WAIT;
               end
            end
         end
         ST_DIV_S: begin
            quo_in = step_quo;
            rem_in = step_rem;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               held_speed_in = step_quo[SPW-1:0];
               res_speed_in  = step_quo[SPW-1:0];
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // Hand the finished item to the output register once it is free.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_scaled_in = res_scaled_ff;
               rsp_speed_in  = res_speed_ff;
               rsp_dir_in    = res_dir_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         numerator_ff   <= '0;
         stall_limit_ff <= enc_sdm_pkg::STALL_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            enc_sdm_pkg::CSR_SPEED_NUMERATOR: numerator_ff   <= csr_wdata[SPW-1:0];
            enc_sdm_pkg::CSR_STALL_LIMIT:     stall_limit_ff <= csr_wdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control and measurement state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_stamp_ff <= '0;
         period_ff     <= '0;
         dir_ff        <= enc_sdm_pkg::DIR_STOP;
         tick_ff       <= '0;
         first_edge_ff <= 1'b1;
         held_speed_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_stamp_ff <= last_stamp_in;
         period_ff     <= period_in;
         dir_ff        <= dir_in;
         tick_ff       <= tick_in;
         first_edge_ff <= first_edge_in;
         held_speed_ff <= held_speed_in;
      end
   end

   // Divider and result payload registers.
   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      cnt_ff        <= cnt_in;
      res_scaled_ff <= res_scaled_in;
      res_speed_ff  <= res_speed_in;
      res_dir_ff    <= res_dir_in;
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_speed_ff  <= rsp_speed_in;
      rsp_dir_ff    <= rsp_dir_in;
   end

endmodule

`default_nettype wire
